@@ rtl/hashed_sorted_chain_table_core_macros.svh @@
// Assertion macros for the checker file of the chained table core.
`ifndef HASHED_SORTED_CHAIN_TABLE_CORE_MACROS_SVH
`define HASHED_SORTED_CHAIN_TABLE_CORE_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define HSCT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: label");

// Consequent in the cycle after the antecedent.
`define HSCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: label");

`endif

@@ rtl/hsct_pkg.sv @@
// ----------------------------------------------------------------------------
// hsct_pkg
// Types, sizes and the key hash of the chained table core.
// ----------------------------------------------------------------------------
package hsct_pkg;

   localparam int unsigned POOL    = 1024;
   localparam int unsigned BUCKETS = 256;
   localparam int unsigned SLOT_W  = $clog2(POOL);
   localparam int unsigned LINK_W  = SLOT_W + 1;
   localparam int unsigned BKT_W   = $clog2(BUCKETS);
   localparam int unsigned CNT_W   = 11;
   localparam int unsigned NB_W    = 9;
   localparam int unsigned HASH_W  = 12;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned HD_W    = 16;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL);

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_LOOKUP,
      OP_REMOVE,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_HEAD,
      S_HWAIT,
      S_WALK,
      S_NODE,
      S_ACT,
      S_POP,
      S_INS,
      S_LINK,
      S_DONE
   } state_type;

   // Shift-and-xor fold of a key down to the hash width.
   function automatic logic [HASH_W-1:0] fold_key(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] h;
      logic [KEY_W-1:0] g;
      h = key + 32'h0000_0044;
      g = h & 32'hff00_0000;
      h = h ^ g;
      h = h ^ (g >> 20);
      g = h & 32'hffff_f000;
      h = h ^ g;
      h = h ^ (g >> 12);
      h = h ^ (h >> 6);
      return h[HASH_W-1:0];
   endfunction

endpackage

@@ rtl/hashed_sorted_chain_table_core.sv @@
// ----------------------------------------------------------------------------
// hashed_sorted_chain_table_core
// Keyed table of hashed buckets with chains kept in ascending key order.
// ----------------------------------------------------------------------------
// One operation is handled at a time. After start is taken, busy stays high
// until the result word has been shown on the rsp_ ports for its single
// cycle, marked by rsp_valid; the receiver cannot stall it. A clear goes
// straight to the result word. Other operations run a bit-serial reduction
// of the hash by the bucket count, fetch the bucket head, visit the chain
// nodes in turn (one read of the node memory and its compare each, and a
// last check when the walk runs off the end of the chain), then update the
// lists and return the word. The block returns to idle after each operation,
// and only there is the next start taken.
module hashed_sorted_chain_table_core
   import hsct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_opcode,
   input  logic [KEY_W-1:0]     req_key,
   input  logic [HD_W-1:0]      req_entry_handle,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [HD_W-1:0]      rsp_found_handle,
   output logic [CNT_W-1:0]     rsp_entry_count,
   input  logic                 csr_wr_en,
   input  logic [NB_W-1:0]      csr_wr_data
);

   // memories
   logic [LINK_W-1:0] head_mem [BUCKETS];
   logic [KEY_W-1:0]  key_mem  [POOL];
   logic [HD_W-1:0]   hd_mem   [POOL];
   logic [LINK_W-1:0] link_mem [POOL];
   logic [SLOT_W-1:0] free_mem [POOL];

   logic [LINK_W-1:0] head_q;
   logic [KEY_W-1:0]  key_q;
   logic [HD_W-1:0]   hd_q;
   logic [LINK_W-1:0] link_q;
   logic [SLOT_W-1:0] free_q;

   // registers
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [HD_W-1:0]   hd_ff, hd_in;
   logic [NB_W-1:0]   num_buckets_ff, num_buckets_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [NB_W-1:0]   rem_ff, rem_in;
   logic [3:0]        div_cnt_ff, div_cnt_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic              head_vq_ff, head_vq_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic              found_ff, found_in;
   logic [HD_W-1:0]   cur_hd_ff, cur_hd_in;
   logic [LINK_W-1:0] cur_link_ff, cur_link_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [CNT_W-1:0]  low_mark_ff, low_mark_in;
   logic [BUCKETS-1:0] head_valid_ff, head_valid_in;
   status_type        status_ff, status_in;
   logic [HD_W-1:0]   handle_ff, handle_in;

   // memory ports
   logic              head_we;
   logic [BKT_W-1:0]  head_addr;
   logic [LINK_W-1:0] head_wd;
   logic              node_we;
   logic [SLOT_W-1:0] node_ra;
   logic              link_we;
   logic [SLOT_W-1:0] link_wa;
   logic [LINK_W-1:0] link_wd;
   logic              free_we;
   logic [SLOT_W-1:0] free_addr;

   logic [NB_W-1:0]   neff;
   logic [NB_W:0]     trial;
   logic [CNT_W-1:0]  fc_m1;

   always_comb begin
      if (num_buckets_ff == '0) begin
         neff = NB_W'(1);
      end else if (num_buckets_ff > NB_W'(BUCKETS)) begin
         neff = NB_W'(BUCKETS);
      end else begin
         neff = num_buckets_ff;
      end
   end

   assign trial = {rem_ff, dvd_ff[HASH_W-1]};
   assign fc_m1 = free_count_ff - CNT_W'(1);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      hd_in          = hd_ff;
      num_buckets_in = num_buckets_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      bucket_in      = bucket_ff;
      head_vq_in     = head_vq_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      found_in       = found_ff;
      cur_hd_in      = cur_hd_ff;
      cur_link_in    = cur_link_ff;
      slot_in        = slot_ff;
      free_count_in  = free_count_ff;
      stored_in      = stored_ff;
      low_mark_in    = low_mark_ff;
      head_valid_in  = head_valid_ff;
      status_in      = status_ff;
      handle_in      = handle_ff;
      head_we        = 1'b0;
      head_addr      = bucket_ff;
      head_wd        = cur_link_ff;
      node_we        = 1'b0;
      node_ra        = cur_ff[SLOT_W-1:0];
      link_we        = 1'b0;
      link_wa        = prev_ff[SLOT_W-1:0];
      link_wd        = cur_link_ff;
      free_we        = 1'b0;
      free_addr      = fc_m1[SLOT_W-1:0];

      if (csr_wr_en) begin
         num_buckets_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_opcode);
               key_in     = req_key;
               hd_in      = req_entry_handle;
               dvd_in     = fold_key(req_key);
               rem_in     = '0;
               div_cnt_in = '0;
               status_in  = ST_OK;
               handle_in  = '0;
               if (op_type'(req_opcode) == OP_CLEAR) begin
                  head_valid_in = '0;
                  free_count_in = CNT_W'(POOL);
                  low_mark_in   = CNT_W'(POOL);
                  stored_in     = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // One quotient bit per cycle; the remainder stays below the divisor.
            if (trial >= {1'b0, neff}) begin
               rem_in = NB_W'(trial - {1'b0, neff});
            end else begin
               rem_in = trial[NB_W-1:0];
            end
            dvd_in     = {dvd_ff[HASH_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'(HASH_W - 1)) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            head_addr  = rem_ff[BKT_W-1:0];
            bucket_in  = rem_ff[BKT_W-1:0];
            head_vq_in = head_valid_ff[rem_ff[BKT_W-1:0]];
            state_in   = S_HWAIT;
         end
         S_HWAIT: begin
            // The head was read at this bucket's address in the previous cycle.
            cur_in   = head_vq_ff ? head_q : NIL;
            prev_in  = NIL;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (cur_ff[SLOT_W]) begin
               found_in = 1'b0;
               state_in = S_ACT;
            end else begin
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            if (key_q < key_ff) begin
               prev_in  = cur_ff;
               cur_in   = link_q;
               state_in = S_WALK;
            end else begin
               found_in    = (key_q == key_ff);
               cur_hd_in   = hd_q;
               cur_link_in = link_q;
               state_in    = S_ACT;
            end
         end
         S_ACT: begin
            state_in = S_DONE;
            case (op_ff)
               OP_INSERT: begin
                  if (free_count_ff == '0) begin
                     status_in = ST_FULL;
                  end else begin
                     free_count_in = fc_m1;
                     // Stack entries below the low mark were never rewritten.
                     if (fc_m1 < low_mark_ff) begin
                        slot_in     = fc_m1[SLOT_W-1:0];
                        low_mark_in = fc_m1;
                        state_in    = S_INS;
                     end else begin
                        state_in = S_POP;
                     end
                  end
               end
               OP_LOOKUP: begin
                  if (found_ff) begin
                     handle_in = cur_hd_ff;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               OP_REMOVE: begin
                  if (found_ff) begin
                     handle_in = cur_hd_ff;
                     if (prev_ff[SLOT_W]) begin
                        head_we                  = 1'b1;
                        head_wd                  = cur_link_ff;
                        head_valid_in[bucket_ff] = 1'b1;
                     end else begin
                        link_we = 1'b1;
                        link_wa = prev_ff[SLOT_W-1:0];
                        link_wd = cur_link_ff;
                     end
                     if (free_count_ff < CNT_W'(POOL)) begin
                        free_we       = 1'b1;
                        free_addr     = free_count_ff[SLOT_W-1:0];
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                     if (stored_ff != '0) begin
                        stored_in = stored_ff - CNT_W'(1);
                     end
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_POP: begin
            // free_addr still points at the popped stack entry.
            free_addr = free_count_ff[SLOT_W-1:0];
            slot_in   = free_q;
            state_in  = S_INS;
         end
         S_INS: begin
            node_we  = 1'b1;
            link_we  = 1'b1;
            link_wa  = slot_ff;
            link_wd  = cur_ff;
            state_in = S_LINK;
         end
         S_LINK: begin
            if (prev_ff[SLOT_W]) begin
               head_we                  = 1'b1;
               head_wd                  = {1'b0, slot_ff};
               head_valid_in[bucket_ff] = 1'b1;
            end else begin
               link_we = 1'b1;
               link_wa = prev_ff[SLOT_W-1:0];
               link_wd = {1'b0, slot_ff};
            end
            stored_in = stored_ff + CNT_W'(1);
            state_in  = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         num_buckets_ff <= NB_W'(BUCKETS);
         free_count_ff  <= CNT_W'(POOL);
         stored_ff      <= '0;
         low_mark_ff    <= CNT_W'(POOL);
         head_valid_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         num_buckets_ff <= num_buckets_in;
         free_count_ff  <= free_count_in;
         stored_ff      <= stored_in;
         low_mark_ff    <= low_mark_in;
         head_valid_ff  <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      hd_ff       <= hd_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      bucket_ff   <= bucket_in;
      head_vq_ff  <= head_vq_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      found_ff    <= found_in;
      cur_hd_ff   <= cur_hd_in;
      cur_link_ff <= cur_link_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      handle_ff   <= handle_in;
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_addr] <= head_wd;
      end
      head_q <= head_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         key_mem[slot_ff] <= key_ff;
         hd_mem[slot_ff]  <= hd_ff;
      end
      key_q <= key_mem[node_ra];
      hd_q  <= hd_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_q <= link_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_addr] <= cur_ff[SLOT_W-1:0];
      end
      free_q <= free_mem[free_addr];
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_DONE);
   assign rsp_status       = status_ff;
   assign rsp_found_handle = handle_ff;
   assign rsp_entry_count  = stored_ff;

endmodule

@@ rtl/hsct_checker.sv @@
// ----------------------------------------------------------------------------
// hsct_checker
// Port-level checks of the chained table core, bound into the core module.
// ----------------------------------------------------------------------------
`include "hashed_sorted_chain_table_core_macros.svh"

module hsct_checker
   import hsct_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [1:0]       rsp_status,
   input logic [HD_W-1:0]  rsp_found_handle,
   input logic [CNT_W-1:0] rsp_entry_count
);

   // A word only appears while an operation is in flight.
   `HSCT_ASSERT_SAME(a_rsp_in_op, clock, reset, rsp_valid, busy)
   // A taken operation holds the block busy.
   `HSCT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // Exactly one word per operation: the strobe is a single cycle.
   `HSCT_ASSERT_NEXT(a_one_word, clock, reset, rsp_valid, !rsp_valid && !busy)
   // A failed operation carries no handle, and the entry count stays within the pool.
   `HSCT_ASSERT_SAME(a_fail_handle, clock, reset,
      rsp_valid && rsp_status != ST_OK, rsp_found_handle == '0 && rsp_entry_count <= CNT_W'(POOL))

endmodule

bind hashed_sorted_chain_table_core hsct_checker u_hsct_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_found_handle (rsp_found_handle),
   .rsp_entry_count  (rsp_entry_count)
);
